// ===== src/ksct_pkg.sv =====
// ----------------------------------------------------------------------------
// ksct_pkg: shared types and constants
// Request and result beat layouts, request and status codes, controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ksct_pkg;

  localparam int TAG_W   = 16;
  localparam int AMT_W   = 32;
  localparam int COUNT_W = 31;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_SET_CAP   = 2'd0,
    REQ_SET_COUNT = 2'd1,
    REQ_ADD       = 2'd2,
    REQ_REMOVE    = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_INVALID_TAG = 2'd1,
    ST_NOT_FOUND   = 2'd2,
    ST_FULL        = 2'd3
  } status_code_t;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [TAG_W-1:0]       tag;
    logic signed [AMT_W-1:0] amount;
    logic                   can_add;
    logic                   remove_at_zero;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic               event_valid;
    logic               event_removed;
    logic [COUNT_W-1:0] event_count;
    logic [COUNT_W-1:0] event_cap;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_MATCH = 2'd1,
    S_READ  = 2'd2,
    S_EXEC  = 2'd3
  } state_t;

  typedef struct packed {
    logic capture;
    logic match;
    logic read;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic res_busy;
  } dp_status_t;

endpackage

// ===== src/ksct_stream_if.sv =====
// ----------------------------------------------------------------------------
// ksct_stream_if: valid/ready channel
// Carries one beat of payload type T from a source to a sink.
// ----------------------------------------------------------------------------
interface ksct_stream_if #(parameter type T = logic);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== src/ksct_ram.sv =====
// ----------------------------------------------------------------------------
// ksct_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ksct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ksct_ctrl.sv =====
// ----------------------------------------------------------------------------
// ksct_ctrl: request sequencer
// Steps one request through match, slot select and read, and execute.
// ----------------------------------------------------------------------------
module ksct_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ksct_pkg::dp_status_t   stat,
  output ksct_pkg::ctrl_cmd_t    cmd
);

  import ksct_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_MATCH;
      S_MATCH: state_next = S_READ;
      S_READ:  state_next = S_EXEC;
      S_EXEC:  if (!stat.res_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs. No request beat is taken while reset is held.
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        in_ready    = !rst;
        cmd.capture = in_valid && !rst;
      end
      S_MATCH: cmd.match = 1'b1;
      S_READ:  cmd.read  = 1'b1;
      S_EXEC:  cmd.exec  = !stat.res_busy;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/ksct_datapath.sv =====
// ----------------------------------------------------------------------------
// ksct_datapath: tag match, count arithmetic and table storage
// Holds tags and used bits in flops, counts and caps in a RAM, and the
// result register that feeds the output channel.
// ----------------------------------------------------------------------------
module ksct_datapath #(
  parameter int ENTRIES  = 16,
  parameter int TAG_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ksct_pkg::req_t       req_data,
  input  ksct_pkg::ctrl_cmd_t  cmd,
  output ksct_pkg::dp_status_t stat,
  output ksct_pkg::rsp_t       rsp_data,
  output logic                 rsp_valid,
  input  logic                 rsp_ready
);

  import ksct_pkg::*;

  localparam int KEY_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RAM_W = 2 * COUNT_W;

  req_t               req_q;
  logic [KEY_W-1:0]   req_key;
  logic [KEY_W-1:0]   keys [ENTRIES];
  logic [ENTRIES-1:0] used;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   slot;
  logic               hit_found;
  logic               free_found;

  logic               ram_we;
  logic [RAM_W-1:0]   ram_wdata;
  logic [RAM_W-1:0]   ram_rdata;

  // Capture the request beat.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_data;
    end
  end

  assign req_key = req_q.tag[KEY_W-1:0];

  // Compare the key against every stored tag.
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      for (int i = 0; i < ENTRIES; i++) begin
        hit_vec[i] <= used[i] && (keys[i] == req_key);
      end
      free_vec <= ~used;
    end
  end

  // Lowest matching slot and lowest free slot.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = IDX_W'(i);
      if (free_vec[i]) free_idx = IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      hit_found  <= |hit_vec;
      free_found <= |free_vec;
      slot       <= (|hit_vec) ? hit_idx : free_idx;
    end
  end

  // Count and cap storage; the read is issued at the matching slot.
  ksct_ram #(.WIDTH(RAM_W), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .re    (cmd.read),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  // Request arithmetic.
  logic signed [AMT_W-1:0] amt;
  logic                    amt_le0;
  logic                    rejected;
  logic [COUNT_W-1:0]      base_count;
  logic [COUNT_W-1:0]      base_cap;
  logic [COUNT_W-1:0]      cap_eff;
  logic [COUNT_W-1:0]      hi;
  logic signed [33:0]      base34;
  logic signed [33:0]      amt34;
  logic signed [33:0]      val;
  logic                    val_le0;
  logic [COUNT_W-1:0]      new_count;
  logic                    zero_hit;
  logic                    do_delete;
  logic                    may_insert;
  logic                    do_write;
  logic                    do_insert;
  rsp_t                    res;

  always_comb begin
    amt        = req_q.amount;
    amt_le0    = amt[AMT_W-1] || (amt == '0);
    rejected   = ((req_q.req_type == REQ_ADD) && amt[AMT_W-1]) ||
                 ((req_q.req_type == REQ_REMOVE) && amt_le0);
    base_count = hit_found ? ram_rdata[RAM_W-1:COUNT_W] : '0;
    base_cap   = hit_found ? ram_rdata[COUNT_W-1:0] : '0;
    cap_eff    = (req_q.req_type == REQ_SET_CAP) ?
                 (amt_le0 ? '0 : amt[COUNT_W-1:0]) : base_cap;
    hi         = (cap_eff == '0) ? COUNT_MAX : cap_eff;
    base34     = $signed({3'b000, base_count});
    amt34      = $signed({{2{amt[AMT_W-1]}}, amt});

    case (req_q.req_type)
      REQ_SET_CAP:   val = base34;
      REQ_SET_COUNT: val = amt34;
      REQ_ADD:       val = base34 + amt34;
      REQ_REMOVE:    val = base34 - amt34;
      default:       val = base34;
    endcase

    // Clamp into 0..hi.
    val_le0 = val[33] || (val == '0);
    if (val_le0) begin
      new_count = '0;
    end else if (val[32:0] > {2'b00, hi}) begin
      new_count = hi;
    end else begin
      new_count = val[COUNT_W-1:0];
    end

    zero_hit  = (req_q.req_type == REQ_REMOVE) ? val_le0 : amt_le0;
    do_delete = ((req_q.req_type == REQ_SET_COUNT) || (req_q.req_type == REQ_REMOVE)) &&
                zero_hit && req_q.remove_at_zero;

    case (req_q.req_type)
      REQ_SET_CAP:   may_insert = req_q.can_add;
      REQ_SET_COUNT: may_insert = req_q.can_add && !req_q.remove_at_zero;
      REQ_ADD:       may_insert = req_q.can_add;
      REQ_REMOVE:    may_insert = 1'b0;
      default:       may_insert = 1'b0;
    endcase

    // Outcome of the request.
    res       = '0;
    do_write  = 1'b0;
    do_insert = 1'b0;
    if (req_key == '0) begin
      res.status = ST_INVALID_TAG;
    end else if (rejected) begin
      res.status = ST_NOT_FOUND;
    end else if (hit_found) begin
      res.status      = ST_DONE;
      res.event_valid = 1'b1;
      if (do_delete) begin
        res.event_removed = 1'b1;
      end else begin
        do_write        = 1'b1;
        res.count       = new_count;
        res.event_count = new_count;
        res.event_cap   = cap_eff;
      end
    end else if (!may_insert) begin
      res.status = ST_NOT_FOUND;
    end else if (!free_found) begin
      res.status = ST_FULL;
    end else begin
      do_write        = 1'b1;
      do_insert       = 1'b1;
      res.status      = ST_DONE;
      res.event_valid = 1'b1;
      res.count       = new_count;
      res.event_count = new_count;
      res.event_cap   = cap_eff;
    end
  end

  assign ram_we    = cmd.exec && do_write;
  assign ram_wdata = {new_count, cap_eff};

  // Used bits and tags.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.exec) begin
      if (hit_found && do_delete && (res.event_removed)) begin
        used[slot] <= 1'b0;
      end else if (do_insert) begin
        used[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_insert) begin
      keys[slot] <= req_key;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_data <= res;
    end
  end

  assign stat.res_busy = rsp_valid && !rsp_ready;

endmodule

// ===== src/keyed_saturating_counter_table_top.sv =====
// ----------------------------------------------------------------------------
// keyed_saturating_counter_table_top: tag-keyed table of capped counters
// Top level joining the request sequencer and the table datapath.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the req channel and each gives exactly one beat on the
// rsp channel, in order. A request beat is taken only while the block is
// idle. After acceptance the block compares the tag against all stored
// tags, then picks the slot and reads its count and cap from the RAM, and
// then computes and writes back, loading the result register as it returns
// to idle. The next request can be taken while that result is presented,
// but not before the previous one has gone through the match, RAM read
// and write-back sequence.
// The result register frees the input side: a new request is accepted while
// the previous result still waits. If that result has not been taken when
// the next one is ready, the block holds in the execute step with the
// request channel not ready until the receiver takes the old beat.
// Reset clears all used bits and the sequencer at once; no clearing pass
// runs, and the block is ready as soon as reset drops.
// ----------------------------------------------------------------------------
module keyed_saturating_counter_table_top #(
  parameter int ENTRIES  = 16,
  parameter int TAG_BITS = 16
) (
  input logic          clk,
  input logic          rst,
  ksct_stream_if.sink   req,
  ksct_stream_if.source rsp
);

  import ksct_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;
  logic       in_ready;
  logic       rsp_valid;
  rsp_t       rsp_data;

  ksct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ksct_datapath #(.ENTRIES(ENTRIES), .TAG_BITS(TAG_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req.data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_data  (rsp_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready)
  );

  assign req.ready = in_ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // An accepted request always starts a match in the next cycle.
  a_accept_match: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> cmd.match)
    else $error("accepted request did not start a match");

  // Execute never overwrites a result that is still waiting.
  a_exec_free: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !(rsp_valid && !rsp.ready))
    else $error("execute while result register is held");

  // Execute always presents a result beat.
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> rsp_valid)
    else $error("execute did not load a result");

  // Only one sequencer step is active at a time.
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.match, cmd.read, cmd.exec}))
    else $error("more than one sequencer step active");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the keyed saturating counter table
// Drives request beats and takes result beats with random idle cycles on
// both sides. It keeps a shadow copy of the tag table and predicts each
// result, then compares every result beat field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ksct_pkg::*;

  localparam int ENTRIES       = 16;
  localparam int TAG_BITS      = 16;
  localparam int RANDOM_ITEMS  = 500;
  localparam int SEGMENT_ITEMS = 50;
  localparam int POOL_KEYS     = 48;
  localparam int IDLE_LIMIT    = 400;
  localparam int DRAIN_CYCLES  = 8;

  // Shadow of the tag table and the queue of results still to come.
  class tally_table_scoreboard;
    bit                 used [ENTRIES];
    logic [TAG_W-1:0]   keys [ENTRIES];
    logic [COUNT_W-1:0] counts [ENTRIES];
    logic [COUNT_W-1:0] caps [ENTRIES];
    rsp_t               expected_responses [$];
    int                 errors;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      errors = 0;
    endfunction

    // Clamp to 0..cap, or to 0..COUNT_MAX when the cap is unlimited.
    function automatic logic [COUNT_W-1:0] clamp_count(longint v, logic [COUNT_W-1:0] cap);
      longint hi;
      hi = (cap == '0) ? longint'(COUNT_MAX) : longint'(cap);
      if (v <= 0) return '0;
      if (v > hi) return hi[COUNT_W-1:0];
      return v[COUNT_W-1:0];
    endfunction

    // Work out the result of one accepted request beat and update the table.
    function void predict_response(req_t r);
      rsp_t               e;
      req_code_t          op;
      longint             amt;
      int                 slot;
      int                 spare;
      bit                 zero;
      bit                 may_insert;
      logic [COUNT_W-1:0] new_cap;
      logic [COUNT_W-1:0] new_count;
      e          = '0;
      op         = req_code_t'(r.req_type);
      amt        = longint'($signed(r.amount));
      slot       = -1;
      spare      = -1;
      may_insert = 1'b0;
      new_cap    = '0;
      new_count  = '0;
      if (r.tag == '0) begin
        e.status = ST_INVALID_TAG;
      end else if ((op == REQ_ADD && amt < 0) || (op == REQ_REMOVE && amt <= 0)) begin
        e.status = ST_NOT_FOUND;
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (used[i] && keys[i] == r.tag && slot < 0) slot = i;
          if (!used[i] && spare < 0) spare = i;
        end
        if (slot >= 0) begin
          // Hit: modify the existing entry.
          case (op)
            REQ_SET_CAP: begin
              caps[slot]   = (amt <= 0) ? '0 : amt[COUNT_W-1:0];
              counts[slot] = clamp_count(longint'(counts[slot]), caps[slot]);
            end
            REQ_ADD: begin
              counts[slot] = clamp_count(longint'(counts[slot]) + amt, caps[slot]);
            end
            default: begin
              zero = (op == REQ_SET_COUNT) ? (amt <= 0) : (longint'(counts[slot]) <= amt);
              if (zero && r.remove_at_zero)
                used[slot] = 1'b0;
              else if (op == REQ_SET_COUNT)
                counts[slot] = clamp_count(amt, caps[slot]);
              else
                counts[slot] = clamp_count(longint'(counts[slot]) - amt, caps[slot]);
            end
          endcase
          e.status = ST_DONE;
          e.event_valid = 1'b1;
          if (used[slot]) begin
            e.count       = counts[slot];
            e.event_count = counts[slot];
            e.event_cap   = caps[slot];
          end else begin
            e.event_removed = 1'b1;
          end
        end else begin
          // Miss: insert into the lowest free slot where the request allows it.
          case (op)
            REQ_SET_CAP: begin
              may_insert = r.can_add;
              new_cap    = (amt <= 0) ? '0 : amt[COUNT_W-1:0];
            end
            REQ_SET_COUNT: begin
              may_insert = r.can_add && !r.remove_at_zero;
              new_count  = clamp_count(amt, '0);
            end
            REQ_ADD: begin
              may_insert = r.can_add;
              new_count  = clamp_count(amt, '0);
            end
            default: may_insert = 1'b0;
          endcase
          if (!may_insert) begin
            e.status = ST_NOT_FOUND;
          end else if (spare < 0) begin
            e.status = ST_FULL;
          end else begin
            used[spare]   = 1'b1;
            keys[spare]   = r.tag;
            caps[spare]   = new_cap;
            counts[spare] = new_count;
            e.status      = ST_DONE;
            e.count       = new_count;
            e.event_valid = 1'b1;
            e.event_count = new_count;
            e.event_cap   = new_cap;
          end
        end
      end
      expected_responses.push_back(e);
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // Check one result beat against the oldest prediction.
    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_responses.size() == 0) begin
        $display("%0t: result beat with none expected, expected none, actual %p",
                 $time, got);
        errors++;
        return;
      end
      want = expected_responses.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("count", want.count, got.count);
      compare_field("event_valid", want.event_valid, got.event_valid);
      compare_field("event_removed", want.event_removed, got.event_removed);
      compare_field("event_count", want.event_count, got.event_count);
      compare_field("event_cap", want.event_cap, got.event_cap);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  ksct_stream_if #(.T(req_t)) req_if ();
  ksct_stream_if #(.T(rsp_t)) rsp_if ();

  keyed_saturating_counter_table_top #(
    .ENTRIES  (ENTRIES),
    .TAG_BITS (TAG_BITS)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  tally_table_scoreboard table_sb = new();
  int                    idle_cycles = 0;
  bit                    sender_steady = 1'b0;
  logic [TAG_W-1:0]      tag_pool [POOL_KEYS];

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels at the rising edge; the watchdog counts cycles
  // in which neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst && req_if.valid && req_if.ready) table_sb.predict_response(req_if.data);
    if (!rst && rsp_if.valid && rsp_if.ready) table_sb.check_response(rsp_if.data);
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic req_t make_request(req_code_t op, logic [TAG_W-1:0] tag,
                                        logic signed [AMT_W-1:0] amount,
                                        logic can_add, logic remove_at_zero);
    req_t r;
    r.req_type       = op;
    r.tag            = tag;
    r.amount         = amount;
    r.can_add        = can_add;
    r.remove_at_zero = remove_at_zero;
    return r;
  endfunction

  // Amounts lean toward small values so that counts reach zero and caps bite.
  function automatic logic signed [AMT_W-1:0] draw_amount();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return 32'sd0;
          1: return 32'sd1;
          2: return -32'sd1;
          3: return 32'sh7FFF_FFFF;
          4: return 32'sh8000_0000;
          default: return 32'sh7FFF_FFFE;
        endcase
      end
      1, 2, 3, 4, 5: return $urandom_range(0, 40);
      6: return -$signed(32'($urandom_range(1, 40)));
      7: return $urandom();
      8: return $urandom_range(0, 200);
      default: return 32'h7FFF_FF00 + $urandom_range(0, 255);
    endcase
  endfunction

  // Present one request beat after an idle gap and hold it until taken.
  // With no gap, valid stays high across the falling edge.
  task automatic send_request(input req_t r);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.data  = r;
    req_if.valid = 1'b1;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Result side: a random stall before each beat, with runs of no stall.
  initial begin : result_sink
    int stall;
    int beats;
    bit steady;
    rsp_if.ready = 1'b0;
    beats = 0;
    steady = 1'b0;
    @(negedge clk);
    forever begin
      if (beats % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      stall = steady ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        rsp_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      beats++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [TAG_W-1:0] candidate;
    logic [TAG_W-1:0] tag;
    bit               dup;
    int               pool_size;
    int               pool_choice [5];
    req_t             r;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    pool_choice  = '{40, 12, 3, 24, 48};

    // Key pool: the tag extremes first, the rest distinct random nonzero tags.
    tag_pool[0] = 16'hFFFF;
    tag_pool[1] = 16'h8000;
    tag_pool[2] = 16'h0001;
    for (int i = 3; i < POOL_KEYS; i++) begin
      do begin
        candidate = TAG_W'($urandom_range(1, 65535));
        dup = 1'b0;
        for (int j = 0; j < i; j++) if (tag_pool[j] == candidate) dup = 1'b1;
      end while (dup);
      tag_pool[i] = candidate;
    end

    // Hold reset, then release it at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: invalid tag, rejections, misses, saturation and deletes.
    send_request(make_request(REQ_SET_COUNT, 16'h0000, 32'sd5, 1'b1, 1'b0));
    send_request(make_request(REQ_REMOVE, 16'h0001, 32'sd5, 1'b1, 1'b1));
    send_request(make_request(REQ_ADD, 16'h0001, -32'sd1, 1'b1, 1'b0));
    send_request(make_request(REQ_REMOVE, 16'h0001, 32'sd0, 1'b1, 1'b0));
    send_request(make_request(REQ_SET_COUNT, 16'h0001, 32'sd9, 1'b0, 1'b0));
    send_request(make_request(REQ_SET_COUNT, 16'h0001, 32'sd9, 1'b1, 1'b1));
    send_request(make_request(REQ_SET_CAP, 16'h0001, 32'sd9, 1'b0, 1'b0));
    send_request(make_request(REQ_SET_COUNT, 16'hFFFF, 32'sh7FFF_FFFF, 1'b1, 1'b0));
    send_request(make_request(REQ_ADD, 16'hFFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0));
    send_request(make_request(REQ_SET_CAP, 16'hFFFF, 32'sd100, 1'b0, 1'b0));
    send_request(make_request(REQ_ADD, 16'hFFFF, 32'sd50, 1'b0, 1'b0));
    send_request(make_request(REQ_REMOVE, 16'hFFFF, 32'sd30, 1'b0, 1'b0));
    send_request(make_request(REQ_SET_CAP, 16'hFFFF, -32'sd1, 1'b0, 1'b0));
    send_request(make_request(REQ_SET_CAP, 16'h8000, 32'sh8000_0000, 1'b1, 1'b0));
    send_request(make_request(REQ_SET_COUNT, 16'h8000, -32'sd5, 1'b0, 1'b0));
    send_request(make_request(REQ_REMOVE, 16'hFFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0));
    send_request(make_request(REQ_REMOVE, 16'hFFFF, 32'sd1, 1'b0, 1'b1));
    send_request(make_request(REQ_SET_COUNT, 16'h8000, 32'sd0, 1'b0, 1'b1));
    send_request(make_request(REQ_SET_COUNT, 16'h00FF, -32'sd7, 1'b1, 1'b0));
    send_request(make_request(REQ_ADD, 16'h1234, 32'sd0, 1'b1, 1'b1));
    send_request(make_request(REQ_SET_CAP, 16'h1234, 32'sh7FFF_FFFF, 1'b0, 1'b1));
    send_request(make_request(REQ_ADD, 16'h1234, 32'sh7FFF_FFFF, 1'b0, 1'b1));

    // Random part in segments; each segment uses a window of the key pool.
    // Wide windows fill the table, narrow ones hammer a few entries.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_ITEMS == 0) begin
        pool_size = pool_choice[(n / SEGMENT_ITEMS) % 5];
        sender_steady = ($urandom_range(0, 3) == 0);
      end
      case ($urandom_range(0, 29))
        0: tag = '0;
        1: tag = TAG_W'($urandom_range(0, 65535));
        default: tag = tag_pool[$urandom_range(0, pool_size - 1)];
      endcase
      r = make_request(req_code_t'($urandom_range(0, 3)), tag, draw_amount(),
                       ($urandom_range(0, 9) < 8), 1'($urandom_range(0, 1)));
      send_request(r);
    end
    @(negedge clk);
    req_if.valid = 1'b0;

    // Drain the remaining results, then give the block a few more cycles.
    while (table_sb.expected_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (table_sb.errors == 0 && table_sb.expected_responses.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ksct_pkg.sv
src/ksct_stream_if.sv
src/ksct_ram.sv
src/ksct_ctrl.sv
src/ksct_datapath.sv
src/keyed_saturating_counter_table_top.sv
tb/sv/tb.sv
